// ===== hw/rtl/obpc_pkg.sv =====
`default_nettype none
package obpc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned GainW   = 31;
  localparam int unsigned OpW     = 33;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned DivW    = 57;
  localparam int unsigned QuotW   = 25;
  localparam int unsigned CntW    = 5;
  localparam int unsigned SumW    = 34;
  localparam int unsigned TermW   = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic signed [DataW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic [GainW-1:0] PROP_GAIN_RST    = 31'd13421773;
  localparam logic [GainW-1:0] DIFF_GAIN_RST    = 31'd3355443;
  localparam logic [GainW-1:0] DIST_GAIN_RST    = 31'd1677722;
  localparam logic [GainW-1:0] DRIVE_LIMIT_RST  = 31'd11744051;
  localparam logic [GainW-1:0] INVERSE_MASS_RST = 31'd11358982;

  // dt and dt*dt/2 in Q0.40
  localparam logic [31:0] DT_Q40      = 32'd1099511628;
  localparam logic [31:0] HALF_DT2_Q40 = 32'd549756;
  localparam logic [31:0] LN2_Q32      = 32'd2977044472;

  localparam logic [QuotW-1:0] ONE_Q24 = 25'd16777216;
  localparam logic [QuotW-1:0] K_MAX   = 25'd23;
  localparam logic [CntW-1:0]  K_STEPS = 5'd5;
  localparam logic [CntW-1:0]  Q_STEPS = 5'd25;
  localparam logic [3:0]       N_FIRST = 4'd2;
  localparam logic [3:0]       N_LAST  = 4'd13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT     = 3'd0,
    CFG_PROP_GAIN    = 3'd1,
    CFG_DIFF_GAIN    = 3'd2,
    CFG_DIST_GAIN    = 3'd3,
    CFG_DRIVE_LIMIT  = 3'd4,
    CFG_INVERSE_MASS = 3'd5
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P,
    ST_D,
    ST_W,
    ST_U,
    ST_A,
    ST_V,
    ST_AH,
    ST_AD,
    ST_NV,
    ST_T_START,
    ST_T_K,
    ST_T_M1,
    ST_T_M2,
    ST_T_M3,
    ST_T_DEN,
    ST_T_Q,
    ST_T_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [OpW-1:0] a;
    logic signed [OpW-1:0] b;
    logic                  wide;   // shift by 40 instead of 24
  } mul_req_t;

  typedef struct packed {
    logic            start;
    logic [CntW-1:0] count;
  } div_req_t;

  function automatic logic signed [DataW-1:0] sat_add(input logic signed [DataW-1:0] x,
                                                       input logic signed [DataW-1:0] y);
    logic signed [DataW:0] s;
    s = {x[DataW-1], x} + {y[DataW-1], y};
    if (s[DataW] != s[DataW-1]) begin
      sat_add = s[DataW] ? Q_MIN : Q_MAX;
    end else begin
      sat_add = s[DataW-1:0];
    end
  endfunction

  function automatic logic signed [DataW-1:0] sat_sub(input logic signed [DataW-1:0] x,
                                                       input logic signed [DataW-1:0] y);
    logic signed [DataW:0] s;
    s = {x[DataW-1], x} - {y[DataW-1], y};
    if (s[DataW] != s[DataW-1]) begin
      sat_sub = s[DataW] ? Q_MIN : Q_MAX;
    end else begin
      sat_sub = s[DataW-1:0];
    end
  endfunction

  function automatic logic signed [OpW-1:0] sx(input logic signed [DataW-1:0] v);
    sx = {v[DataW-1], v};
  endfunction

  function automatic logic signed [OpW-1:0] gx(input logic [GainW-1:0] g);
    gx = {2'b00, g};
  endfunction

  // floor(2^32 / n) for the series divisors
  function automatic logic [31:0] recip(input logic [3:0] n);
    logic [31:0] m;
    unique case (n)
      4'd2:    m = 32'd2147483648;
      4'd3:    m = 32'd1431655765;
      4'd4:    m = 32'd1073741824;
      4'd5:    m = 32'd858993459;
      4'd6:    m = 32'd715827882;
      4'd7:    m = 32'd613566756;
      4'd8:    m = 32'd536870912;
      4'd9:    m = 32'd477218588;
      4'd10:   m = 32'd429496729;
      4'd11:   m = 32'd390451572;
      4'd12:   m = 32'd357913941;
      4'd13:   m = 32'd330382099;
      default: m = 32'd0;
    endcase
    recip = m;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/obpc_mul.sv =====
`default_nettype none
module obpc_mul (
  input  wire logic                               clk,
  input  wire obpc_pkg::mul_req_t                 req,
  output logic [obpc_pkg::ProdW-1:0]              prod,
  output logic signed [obpc_pkg::DataW-1:0]       res
);
  import obpc_pkg::*;

  localparam logic signed [ProdW-1:0] Rnd24 = ProdW'(64'd1 << 23);
  localparam logic signed [ProdW-1:0] Rnd40 = ProdW'(64'd1 << 39);
  localparam logic signed [ProdW-1:0] SatHi = ProdW'(Q_MAX);
  localparam logic signed [ProdW-1:0] SatLo = ProdW'(Q_MIN);

  logic signed [ProdW-1:0] a_ext;
  logic signed [ProdW-1:0] b_ext;
  logic signed [ProdW-1:0] prod_q;
  logic                    wide;
  logic signed [ProdW-1:0] rounded;
  logic signed [ProdW-1:0] shifted;

  assign a_ext = {{(ProdW-OpW){req.a[OpW-1]}}, req.a};
  assign b_ext = {{(ProdW-OpW){req.b[OpW-1]}}, req.b};

  always_ff @(posedge clk) begin
    prod_q <= a_ext * b_ext;
    wide   <= req.wide;
  end

  // round half up, floor shift, saturate to q8.24
  always_comb begin
    rounded = prod_q + (wide ? Rnd40 : Rnd24);
    shifted = wide ? (rounded >>> 40) : (rounded >>> 24);
    if (shifted > SatHi) begin
      res = Q_MAX;
    end else if (shifted < SatLo) begin
      res = Q_MIN;
    end else begin
      res = shifted[DataW-1:0];
    end
  end

  assign prod = prod_q;

endmodule
`default_nettype wire

// ===== hw/rtl/obpc_div.sv =====
`default_nettype none
module obpc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire obpc_pkg::div_req_t            req,
  input  wire logic [obpc_pkg::DivW-1:0]     num_hi,
  input  wire logic [obpc_pkg::QuotW-1:0]    num_lo,
  input  wire logic [obpc_pkg::DivW-1:0]     divisor,
  output logic                               busy,
  output logic [obpc_pkg::QuotW-1:0]         quot,
  output logic [obpc_pkg::DivW-1:0]          rem
);
  import obpc_pkg::*;

  logic [DivW-1:0]  dvs;
  logic [QuotW-1:0] bring;
  logic [CntW-1:0]  cnt;
  logic [DivW:0]    trial;
  logic [DivW:0]    diff;
  logic             fits;

  // one restoring step per cycle, numerator bits brought down msb first
  always_comb begin
    trial = {rem, bring[QuotW-1]};
    diff  = trial - {1'b0, dvs};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.count;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= num_hi;
      bring <= num_lo;
      dvs   <= divisor;
      quot  <= '0;
    end else if (busy) begin
      rem   <= fits ? diff[DivW-1:0] : trial[DivW-1:0];
      bring <= {bring[QuotW-2:0], 1'b0};
      quot  <= {quot[QuotW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/observer_based_position_controller.sv =====
// observer based position controller, q8.24 signed fixed point
// input stream: one measured position per control tick on s_axis_tdata
// output stream: the clamped drive on m_axis_tdata, m_axis_tuser[0] set when
// the drive was limited to +/- drive_limit
// config channel: cfg_index selects setpoint, prop_gain, diff_gain,
// dist_gain, drive_limit or inverse_mass (0..5); other indexes are ignored;
// cfg_ready is always high, write only while no item is in flight
// one item at a time: s_axis_tready is high only while the sequencer idles
// a result is valid sooner when both tanh arguments are at or beyond +/-8,
// and later otherwise; the next item can be taken as soon as the result is
// written to the output register
// the longer path comes from the two tanh evaluations: a series up to the 13th
// power on the shared 33x33 multiplier and two restoring divisions on the shared divider
// that retires one quotient bit per cycle
// the result sits in an output register; a stalled receiver holds it, and
// the block takes the next item meanwhile but waits before writing a new one
// reset clears the observer state and loads the default gains
`default_nettype none
module observer_based_position_controller (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [obpc_pkg::DataW-1:0]         s_axis_tdata,   // [31:0] position
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [obpc_pkg::DataW-1:0]              m_axis_tdata,   // [31:0] drive
  output logic [0:0]                              m_axis_tuser,   // [0] clamped
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [obpc_pkg::CfgIdxW-1:0]       cfg_index,
  input  wire logic [obpc_pkg::DataW-1:0]         cfg_data
);
  import obpc_pkg::*;

  state_t state;
  state_t state_next;

  logic signed [DataW-1:0] setpoint;
  logic [GainW-1:0]        prop_gain;
  logic [GainW-1:0]        diff_gain;
  logic [GainW-1:0]        dist_gain;
  logic [GainW-1:0]        drive_limit;
  logic [GainW-1:0]        inverse_mass;

  logic signed [DataW-1:0] last_position;
  logic signed [DataW-1:0] est_position;
  logic signed [DataW-1:0] est_velocity;
  logic signed [DataW-1:0] disturbance;
  logic signed [DataW-1:0] filtered_disturbance;

  logic signed [DataW-1:0] meas;
  logic signed [DataW-1:0] p_term;
  logic signed [DataW-1:0] acc;
  logic signed [DataW-1:0] drive_val;
  logic                    clip;
  logic signed [DataW-1:0] err;
  logic signed [DataW-1:0] accel;
  logic signed [DataW-1:0] np;
  logic signed [DataW-1:0] nv;
  logic signed [DataW-1:0] fnew;

  logic signed [DataW-1:0] tx;
  logic                    tneg;
  logic                    tsel;
  logic [CntW-1:0]         k;
  logic [TermW-1:0]        r;
  logic [TermW-1:0]        term;
  logic [TermW-1:0]        vtmp;
  logic [SumW-1:0]         sum;
  logic [3:0]              n;
  logic [QuotW-1:0]        t;

  logic signed [DataW-1:0] out_drive;
  logic                    out_clip;
  logic                    out_free;

  mul_req_t                mreq;
  logic [ProdW-1:0]        mprod;
  logic signed [DataW-1:0] mres;

  div_req_t                dreq;
  logic [DivW-1:0]         div_hi;
  logic [QuotW-1:0]        div_lo;
  logic [DivW-1:0]         div_dvs;
  logic                    div_busy;
  logic [QuotW-1:0]        div_quot;
  logic [DivW-1:0]         div_rem;

  logic [DataW:0]          tx_ext;
  logic [DataW:0]          ax;
  logic                    tanh_sat;
  logic [TermW-1:0]        q0;
  logic [TermW:0]          q0_inc;
  logic [TermW+4:0]        qn;
  logic [TermW-1:0]        term_new;
  logic [DivW-1:0]         den;
  logic signed [DataW-1:0] tval;
  logic signed [DataW-1:0] lim;
  logic signed [DataW-1:0] nlim;
  logic signed [DataW-1:0] u_raw;
  logic signed [DataW-1:0] u_cl;
  logic                    u_clip;

  obpc_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (mprod),
    .res  (mres)
  );

  obpc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (dreq),
    .num_hi  (div_hi),
    .num_lo  (div_lo),
    .divisor (div_dvs),
    .busy    (div_busy),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata  = out_drive;
  assign m_axis_tuser  = out_clip;

  // datapath helpers
  always_comb begin
    tx_ext   = {tx[DataW-1], tx};
    ax       = tx[DataW-1] ? ((DataW+1)'(0) - tx_ext) : tx_ext;
    tanh_sat = |ax[DataW:27];
    q0       = mprod[63:32];
    q0_inc   = {1'b0, q0} + 1'b1;
    qn       = {4'b0, q0_inc} * {(TermW+1)'(0), n};
    // reciprocal estimate is at most one short
    term_new = ({5'b0, vtmp} >= qn) ? q0_inc[TermW-1:0] : q0;
    den      = ({23'b0, sum} << k) + (DivW'(1) << 32);
    tval     = tneg ? (DataW'(0) - {7'b0, t}) : {7'b0, t};
    lim      = {1'b0, drive_limit};
    nlim     = DataW'(0) - lim;
    u_raw    = sat_sub(acc, mres);
    u_cl     = u_raw;
    u_clip   = 1'b0;
    if (u_raw > lim) begin
      u_cl   = lim;
      u_clip = 1'b1;
    end else if (u_raw < nlim) begin
      u_cl   = nlim;
      u_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mreq       = '0;
    dreq       = '0;
    div_hi     = '0;
    div_lo     = '0;
    div_dvs    = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_P;
      end
      ST_P: begin
        mreq.a     = sx(sat_sub(setpoint, meas));
        mreq.b     = gx(prop_gain);
        state_next = ST_D;
      end
      ST_D: begin
        mreq.a     = sx(sat_sub(meas, last_position));
        mreq.b     = gx(diff_gain);
        state_next = ST_W;
      end
      ST_W: begin
        mreq.a     = sx(filtered_disturbance);
        mreq.b     = gx(dist_gain);
        state_next = ST_U;
      end
      ST_U: begin
        state_next = ST_A;
      end
      ST_A: begin
        mreq.a     = sx(drive_val);
        mreq.b     = gx(inverse_mass);
        state_next = ST_V;
      end
      ST_V: begin
        mreq.a     = sx(est_velocity);
        mreq.b     = {1'b0, DT_Q40};
        mreq.wide  = 1'b1;
        state_next = ST_AH;
      end
      ST_AH: begin
        mreq.a     = sx(accel);
        mreq.b     = {1'b0, HALF_DT2_Q40};
        mreq.wide  = 1'b1;
        state_next = ST_AD;
      end
      ST_AD: begin
        mreq.a     = sx(accel);
        mreq.b     = {1'b0, DT_Q40};
        mreq.wide  = 1'b1;
        state_next = ST_NV;
      end
      ST_NV: begin
        state_next = ST_T_START;
      end
      ST_T_START: begin
        if (tanh_sat) begin
          state_next = ST_T_DONE;
        end else begin
          // k = floor(2|x| / ln2), remainder is the reduced argument
          dreq.start = 1'b1;
          dreq.count = K_STEPS;
          div_hi     = {26'b0, ax[26:0], 4'b0};
          div_dvs    = {25'b0, LN2_Q32};
          state_next = ST_T_K;
        end
      end
      ST_T_K: begin
        if (!div_busy) state_next = ST_T_M1;
      end
      ST_T_M1: begin
        mreq.a     = {1'b0, term};
        mreq.b     = {1'b0, r};
        state_next = ST_T_M2;
      end
      ST_T_M2: begin
        mreq.a     = {1'b0, mprod[63:32]};
        mreq.b     = {1'b0, recip(n)};
        state_next = ST_T_M3;
      end
      ST_T_M3: begin
        state_next = (n == N_LAST) ? ST_T_DEN : ST_T_M1;
      end
      ST_T_DEN: begin
        // q = (2^57 + den/2) / den
        dreq.start = 1'b1;
        dreq.count = Q_STEPS;
        div_hi     = (DivW'(1) << 32) + {26'b0, den[56:26]};
        div_lo     = den[25:1];
        div_dvs    = den;
        state_next = ST_T_Q;
      end
      ST_T_Q: begin
        if (!div_busy) state_next = ST_T_DONE;
      end
      ST_T_DONE: begin
        state_next = tsel ? ST_OUT : ST_T_START;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) meas <= s_axis_tdata;
      end
      ST_D: begin
        p_term <= mres;
      end
      ST_W: begin
        acc <= sat_sub(p_term, mres);
      end
      ST_U: begin
        drive_val <= u_cl;
        clip      <= u_clip;
        err       <= sat_sub(last_position, est_position);
      end
      ST_V: begin
        accel <= mres;
      end
      ST_AH: begin
        np <= sat_add(est_position, mres);
      end
      ST_AD: begin
        np <= sat_add(np, mres);
      end
      ST_NV: begin
        nv   <= sat_add(est_velocity, mres);
        tx   <= err;
        tsel <= 1'b0;
      end
      ST_T_START: begin
        tneg <= tx[DataW-1];
        if (tanh_sat) t <= ONE_Q24;
      end
      ST_T_K: begin
        if (!div_busy) begin
          k    <= div_quot[CntW-1:0];
          r    <= div_rem[TermW-1:0];
          term <= div_rem[TermW-1:0];
          sum  <= (SumW'(1) << 32) + {2'b0, div_rem[TermW-1:0]};
          n    <= N_FIRST;
        end
      end
      ST_T_M2: begin
        vtmp <= mprod[63:32];
      end
      ST_T_M3: begin
        term <= term_new;
        sum  <= sum + {2'b0, term_new};
        n    <= n + 1'b1;
      end
      ST_T_Q: begin
        if (!div_busy) t <= ONE_Q24 - div_quot;
      end
      ST_T_DONE: begin
        if (tsel) begin
          fnew <= sat_add(filtered_disturbance, tval);
        end else begin
          np   <= sat_add(np, tval);
          nv   <= sat_add(nv, tval);
          tx   <= sat_sub(disturbance, filtered_disturbance);
          tsel <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position        <= '0;
      est_position         <= '0;
      est_velocity         <= '0;
      disturbance          <= '0;
      filtered_disturbance <= '0;
    end else if (state == ST_OUT && out_free) begin
      last_position        <= meas;
      est_position         <= np;
      est_velocity         <= nv;
      disturbance          <= err;
      filtered_disturbance <= fnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint     <= '0;
      prop_gain    <= PROP_GAIN_RST;
      diff_gain    <= DIFF_GAIN_RST;
      dist_gain    <= DIST_GAIN_RST;
      drive_limit  <= DRIVE_LIMIT_RST;
      inverse_mass <= INVERSE_MASS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SETPOINT:     setpoint     <= cfg_data;
        CFG_PROP_GAIN:    prop_gain    <= cfg_data[GainW-1:0];
        CFG_DIFF_GAIN:    diff_gain    <= cfg_data[GainW-1:0];
        CFG_DIST_GAIN:    dist_gain    <= cfg_data[GainW-1:0];
        CFG_DRIVE_LIMIT:  drive_limit  <= cfg_data[GainW-1:0];
        CFG_INVERSE_MASS: inverse_mass <= cfg_data[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_drive <= drive_val;
      out_clip  <= clip;
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !div_busy)
    else $error("divider started while busy");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_T_K && !div_busy) |-> div_quot <= K_MAX)
    else $error("range reduction count out of range");

  a_tanh_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_T_DONE |-> t <= ONE_Q24)
    else $error("tanh magnitude above one");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_result_written: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> m_axis_tvalid)
    else $error("finished item not presented");

endmodule
`default_nettype wire
